// ===== hdl/c2cs_pkg.sv =====
// ----------------------------------------------------------------------------
// c2cs_pkg: shared types and constants for the complex 2x2 solver
// Word layouts, division cell payload, status codes and the wide multiply map.
// ----------------------------------------------------------------------------
package c2cs_pkg;

  localparam int DW  = 133;          // |det|^2 and numerator sum width
  localparam int MW  = DW + 16;      // numerator magnitude after the 2^16 scale
  localparam int QB  = 33;           // quotient bits resolved by the cell chain
  localparam int NL  = 4;            // division lanes
  localparam int NW  = 10;           // wide products
  localparam int LAT = 7 + QB + 1;   // accept edge to done

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  typedef struct packed {
    logic signed [31:0] s_r_re;
    logic signed [31:0] s_r_im;
    logic signed [31:0] s_s12_re;
    logic signed [31:0] s_s12_im;
    logic signed [31:0] s_k_re;
    logic signed [31:0] s_k_im;
    logic signed [31:0] d_r_re;
    logic signed [31:0] d_r_im;
    logic signed [31:0] d_s12_re;
    logic signed [31:0] d_s12_im;
    logic signed [31:0] d_k_re;
    logic signed [31:0] d_k_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] central_re;
    logic signed [31:0] central_im;
    logic signed [31:0] tensor_re;
    logic signed [31:0] tensor_im;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [DW-1:0] rem;   // partial remainder
    logic [QB-1:0] shf;   // dividend bits out at the top, quotient bits in at the bottom
    logic          neg;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    logic                vld;
    logic                zero;
    logic [DW-1:0]       dd;
    lane_t [NL-1:0]      ln;
  } cell_t;

  // operand indexes into {det.re, det.im, nc.re, nc.im, nt.re, nt.im}
  localparam logic [2:0] MA [NW] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd4};
  localparam logic [2:0] MB [NW] = '{3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd1};

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    ax = 64'(a);
    bx = 64'(b);
    return ax * bx;
  endfunction

endpackage

// ===== hdl/c2cs_front.sv =====
// ----------------------------------------------------------------------------
// c2cs_front: product and sum pipeline
// Forms det, both numerators, |det|^2 and the scaled numerator magnitudes.
// ----------------------------------------------------------------------------
module c2cs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  c2cs_pkg::in_t    item,
  output c2cs_pkg::cell_t  head
);
  import c2cs_pkg::*;

  logic signed [31:0] ar [3], ai [3], br [3], bi [3];
  logic signed [31:0] cr [3], ci [3], er [3], ei [3];

  // each pair is a*b - c*e
  always_comb begin
    ar[0] = item.s_r_re;   ai[0] = item.s_r_im;   br[0] = item.d_s12_re; bi[0] = item.d_s12_im;
    cr[0] = item.s_s12_re; ci[0] = item.s_s12_im; er[0] = item.d_r_re;   ei[0] = item.d_r_im;
    ar[1] = item.d_s12_re; ai[1] = item.d_s12_im; br[1] = item.s_k_re;   bi[1] = item.s_k_im;
    cr[1] = item.s_s12_re; ci[1] = item.s_s12_im; er[1] = item.d_k_re;   ei[1] = item.d_k_im;
    ar[2] = item.d_k_re;   ai[2] = item.d_k_im;   br[2] = item.s_r_re;   bi[2] = item.s_r_im;
    cr[2] = item.s_k_re;   ci[2] = item.s_k_im;   er[2] = item.d_r_re;   ei[2] = item.d_r_im;
  end

  // stage 1: 32x32 products
  logic               v1;
  logic signed [63:0] p1 [3][8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    for (int j = 0; j < 3; j++) begin
      p1[j][0] <= mul32(ar[j], br[j]);
      p1[j][1] <= mul32(ai[j], bi[j]);
      p1[j][2] <= mul32(cr[j], er[j]);
      p1[j][3] <= mul32(ci[j], ei[j]);
      p1[j][4] <= mul32(ar[j], bi[j]);
      p1[j][5] <= mul32(ai[j], br[j]);
      p1[j][6] <= mul32(cr[j], ei[j]);
      p1[j][7] <= mul32(ci[j], er[j]);
    end
  end

  // stage 2: det, nc, nt
  logic               v2;
  logic signed [65:0] x2 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int j = 0; j < 3; j++) begin
      x2[2*j]   <= 66'(p1[j][0]) - 66'(p1[j][1]) - 66'(p1[j][2]) + 66'(p1[j][3]);
      x2[2*j+1] <= 66'(p1[j][4]) + 66'(p1[j][5]) - 66'(p1[j][6]) - 66'(p1[j][7]);
    end
  end

  // stage 3: partial products of the 66x66 multiplies
  logic signed [33:0] ah [NW], bh [NW];
  logic [31:0]        al [NW], bl [NW];

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      ah[k] = x2[MA[k]][65:32];
      al[k] = x2[MA[k]][31:0];
      bh[k] = x2[MB[k]][65:32];
      bl[k] = x2[MB[k]][31:0];
    end
  end

  logic               v3, z3;
  logic signed [67:0] hh3 [NW];
  logic signed [66:0] hl3 [NW], lh3 [NW];
  logic [63:0]        ll3 [NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    z3 <= (x2[0] == 66'sd0) && (x2[1] == 66'sd0);
    for (int k = 0; k < NW; k++) begin
      hh3[k] <= 68'(ah[k]) * 68'(bh[k]);
      hl3[k] <= 67'(ah[k]) * 67'(signed'({1'b0, bl[k]}));
      lh3[k] <= 67'(signed'({1'b0, al[k]})) * 67'(bh[k]);
      ll3[k] <= 64'(al[k]) * 64'(bl[k]);
    end
  end

  // stage 4: assemble wide products
  logic                v4, z4;
  logic signed [131:0] w4 [NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    z4 <= z3;
    for (int k = 0; k < NW; k++) begin
      w4[k] <= (132'(hh3[k]) <<< 64) + (132'(hl3[k]) <<< 32) + (132'(lh3[k]) <<< 32)
             + 132'(signed'({1'b0, ll3[k]}));
    end
  end

  // stage 5: |det|^2 and numerator * conj(det)
  logic                 v5, z5;
  logic [DW-1:0]        dd5;
  logic signed [DW-1:0] num5 [NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    z5      <= z4;
    dd5     <= DW'(w4[0]) + DW'(w4[1]);
    num5[0] <= DW'(w4[2]) + DW'(w4[3]);
    num5[1] <= DW'(w4[4]) - DW'(w4[5]);
    num5[2] <= DW'(w4[6]) + DW'(w4[7]);
    num5[3] <= DW'(w4[8]) - DW'(w4[9]);
  end

  // stage 6: magnitude with the 2^16 output scale
  logic          v6, z6;
  logic [DW-1:0] dd6;
  logic [MW-1:0] mag6 [NL];
  logic [NL-1:0] neg6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    z6  <= z5;
    dd6 <= dd5;
    for (int l = 0; l < NL; l++) begin
      neg6[l] <= num5[l][DW-1];
      mag6[l] <= {(num5[l][DW-1] ? DW'(-num5[l]) : DW'(num5[l])), 16'd0};
    end
  end

  // stage 7: overflow check and remainder seed for the cell chain
  always_ff @(posedge clk) begin
    if (rst) begin
      head.vld <= 1'b0;
    end else begin
      head.vld <= v6;
    end
    head.zero <= z6;
    head.dd   <= dd6;
    for (int l = 0; l < NL; l++) begin
      head.ln[l].rem <= DW'(mag6[l][MW-1:QB]);
      head.ln[l].shf <= mag6[l][QB-1:0];
      head.ln[l].neg <= neg6[l];
      head.ln[l].ovf <= DW'(mag6[l][MW-1:QB]) >= dd6;
    end
  end

endmodule

// ===== hdl/c2cs_cell.sv =====
// ----------------------------------------------------------------------------
// c2cs_cell: one restoring division step
// Resolves one quotient bit on each of the four lanes and passes the word on.
// ----------------------------------------------------------------------------
module c2cs_cell (
  input  logic             clk,
  input  logic             rst,
  input  c2cs_pkg::cell_t  din,
  output c2cs_pkg::cell_t  dout
);
  import c2cs_pkg::*;

  logic [DW:0]   trial [NL];
  logic [DW:0]   diff  [NL];
  logic [NL-1:0] ge;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      trial[l] = {din.ln[l].rem, din.ln[l].shf[QB-1]};
      diff[l]  = trial[l] - {1'b0, din.dd};
      ge[l]    = trial[l] >= {1'b0, din.dd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.zero <= din.zero;
    dout.dd   <= din.dd;
    for (int l = 0; l < NL; l++) begin
      dout.ln[l].rem <= ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
      dout.ln[l].shf <= {din.ln[l].shf[QB-2:0], ge[l]};
      dout.ln[l].neg <= din.ln[l].neg;
      dout.ln[l].ovf <= din.ln[l].ovf;
    end
  end

  // remainder stays below the divisor on lane 0 while that lane is live
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dout.vld && !dout.zero && !dout.ln[0].ovf |-> dout.ln[0].rem < dout.dd)
    else $error("remainder not below divisor");

endmodule

// ===== hdl/c2cs_round.sv =====
// ----------------------------------------------------------------------------
// c2cs_round: rounding, saturation and result register
// Rounds half away from zero, applies sign, clamps and builds the status.
// ----------------------------------------------------------------------------
module c2cs_round (
  input  logic             clk,
  input  logic             rst,
  input  c2cs_pkg::cell_t  tail,
  output logic             done,
  output c2cs_pkg::out_t   result
);
  import c2cs_pkg::*;

  logic [QB:0]        q   [NL];
  logic [NL-1:0]      sat;
  logic signed [31:0] val [NL];
  out_t               result_next;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      q[l]   = (QB+1)'(tail.ln[l].shf)
             + (QB+1)'({tail.ln[l].rem, 1'b0} >= {1'b0, tail.dd});
      sat[l] = tail.ln[l].ovf
             || (tail.ln[l].neg ? (q[l] > 34'h080000000) : (q[l] > 34'h07fffffff));
      if (sat[l]) begin
        val[l] = tail.ln[l].neg ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        val[l] = tail.ln[l].neg ? 32'((QB+1)'(0) - q[l]) : 32'(q[l]);
      end
    end
    if (tail.zero) begin
      result_next = '{central_re: '0, central_im: '0, tensor_re: '0, tensor_im: '0,
                      status: ST_SINGULAR};
    end else begin
      result_next.central_re = val[0];
      result_next.central_im = val[1];
      result_next.tensor_re  = val[2];
      result_next.tensor_im  = val[3];
      result_next.status     = (|sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.vld;
    end
    result <= result_next;
  end

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_SINGULAR |->
      result.central_re == 0 && result.central_im == 0 &&
      result.tensor_re == 0 && result.tensor_im == 0)
    else $error("singular word with nonzero values");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(tail.vld))
    else $error("done without a word from the chain");

endmodule

// ===== hdl/complex_2x2_cramer_solve.sv =====
// ----------------------------------------------------------------------------
// complex_2x2_cramer_solve: complex 2x2 solve by Cramer's rule
// Central and tensor potentials from six complex correlators per point.
// ----------------------------------------------------------------------------
// usage:
//   drive item and raise start; the word is taken at any edge with start
//   high and busy low. busy is always low, so a new point can enter every
//   cycle, back to back.
//   each word gives one result, shown on result for exactly one cycle with
//   done high. from the accepting edge to the edge that takes the result a word
//   passes 7 multiply and sum stages, 33 division cells
//   (one quotient bit each), one round and output register.
//   throughput is one point per cycle; the 33 cell chain holds up to that
//   many points in flight on four lanes at once.
//   the receiver cannot stall, so results must be taken when done is high.
//   a synchronous reset clears all valid flags; words in flight are dropped.
//   status: ok, singular (zero determinant, values zero) or saturated.
// ----------------------------------------------------------------------------
module complex_2x2_cramer_solve (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  c2cs_pkg::in_t    item,
  output logic             done,
  output c2cs_pkg::out_t   result
);
  import c2cs_pkg::*;

  cell_t chain [QB+1];

  assign busy = 1'b0;

  c2cs_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .head  (chain[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    c2cs_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  c2cs_round u_round (
    .clk    (clk),
    .rst    (rst),
    .tail   (chain[QB]),
    .done   (done),
    .result (result)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a word accepted at the expected latency");

endmodule

// ===== tb/complex_2x2_cramer_solve_test.sv =====
// ----------------------------------------------------------------------------
// complex_2x2_cramer_solve_test: self-checking bench for the 2x2 complex solver
// Drives directed and random correlator words, predicts central and tensor
// potentials with exact wide integer math, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_2x2_cramer_solve_test;
  import c2cs_pkg::*;

  localparam int PW = 200;  // wide enough for every product and the scaled numerators

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  item;
  logic done;
  out_t result;

  out_t want_q[$];
  int   n_err;

  complex_2x2_cramer_solve u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // round n/d half away from zero, d > 0, saturate to 32 bits
  function automatic logic [31:0] quot_sat(input logic signed [PW-1:0] n,
                                           input logic signed [PW-1:0] d,
                                           inout bit sat);
    logic signed [PW-1:0] mag;
    logic signed [PW-1:0] q;
    logic signed [PW-1:0] r;
    bit neg;
    neg = n < 0;
    mag = neg ? -n : n;
    q = mag / d;
    r = mag % d;
    if (2 * r >= d) q = q + 1;
    if (!neg && q > 64'sh7FFFFFFF) begin
      sat = 1;
      return 32'h7FFFFFFF;
    end
    if (neg && q > 64'sh80000000) begin
      sat = 1;
      return 32'h80000000;
    end
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic out_t solve_point(input in_t x);
    logic signed [PW-1:0] srr, sri, ssr, ssi, skr, ski, drr, dri, dsr, dsi, dkr, dki;
    logic signed [PW-1:0] detr, deti, ncr, nci, ntr, nti, dd;
    out_t o;
    bit sat;
    srr = x.s_r_re;   sri = x.s_r_im;   ssr = x.s_s12_re; ssi = x.s_s12_im;
    skr = x.s_k_re;   ski = x.s_k_im;   drr = x.d_r_re;   dri = x.d_r_im;
    dsr = x.d_s12_re; dsi = x.d_s12_im; dkr = x.d_k_re;   dki = x.d_k_im;
    sat = 0;
    o = '0;
    detr = (srr * dsr - sri * dsi) - (ssr * drr - ssi * dri);
    deti = (srr * dsi + sri * dsr) - (ssr * dri + ssi * drr);
    if (detr == 0 && deti == 0) begin
      o.status = ST_SINGULAR;
      return o;
    end
    ncr = (dsr * skr - dsi * ski) - (ssr * dkr - ssi * dki);
    nci = (dsr * ski + dsi * skr) - (ssr * dki + ssi * dkr);
    ntr = (dkr * srr - dki * sri) - (skr * drr - ski * dri);
    nti = (dkr * sri + dki * srr) - (skr * dri + ski * drr);
    dd = detr * detr + deti * deti;
    o.central_re = quot_sat((ncr * detr + nci * deti) * 65536, dd, sat);
    o.central_im = quot_sat((nci * detr - ncr * deti) * 65536, dd, sat);
    o.tensor_re  = quot_sat((ntr * detr + nti * deti) * 65536, dd, sat);
    o.tensor_im  = quot_sat((nti * detr - ntr * deti) * 65536, dd, sat);
    o.status = sat ? ST_SAT : ST_OK;
    return o;
  endfunction

  // result checker
  initial begin
    out_t w;
    n_err = 0;
    forever begin
      @(posedge clk);
      if (!rst && done) begin
        if (want_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result %h", result);
        end else begin
          w = want_q.pop_front();
          if (result.central_re !== w.central_re || result.central_im !== w.central_im ||
              result.tensor_re !== w.tensor_re || result.tensor_im !== w.tensor_im ||
              result.status !== w.status) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: want %h %h %h %h st %0d got %h %h %h %h st %0d",
                       w.central_re, w.central_im, w.tensor_re, w.tensor_im, w.status,
                       result.central_re, result.central_im, result.tensor_re,
                       result.tensor_im, result.status);
          end
        end
      end
    end
  end

  int burst_left;

  // one word, with bursty random gaps; start stays high across back to back words
  task automatic send_word(input in_t x);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    item  <= x;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    want_q.push_back(solve_point(x));
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_part(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic in_t rnd_word;
    in_t x;
    int mode;
    mode = $urandom_range(0, 3);
    x = '0;
    x.s_r_re = rnd_part(mode);   x.s_r_im = rnd_part(mode);
    x.s_s12_re = rnd_part(mode); x.s_s12_im = rnd_part(mode);
    x.s_k_re = rnd_part($urandom_range(0, 3));
    x.s_k_im = rnd_part($urandom_range(0, 3));
    x.d_r_re = rnd_part(mode);   x.d_r_im = rnd_part(mode);
    x.d_s12_re = rnd_part(mode); x.d_s12_im = rnd_part(mode);
    x.d_k_re = rnd_part($urandom_range(0, 3));
    x.d_k_im = rnd_part($urandom_range(0, 3));
    return x;
  endfunction

  task automatic test_extremes;
    in_t x;
    x = '0;
    send_word(x);                       // all zero, singular
    x = {12{32'h7FFFFFFF}};
    send_word(x);                       // proportional rows, singular
    x = {12{32'h80000000}};
    send_word(x);
    x = '0;
    x.s_r_re = 32'h01000000; x.d_s12_re = 32'h01000000;
    x.s_k_re = 32'h02000000; x.d_k_im = 32'hFF000000;
    send_word(x);                       // identity system
    x.s_k_re = 32'h7FFFFFFF; x.s_r_re = 32'h00000001; x.d_s12_re = 32'h00000001;
    send_word(x);                       // tiny det, saturates
    x.s_k_re = 32'h80000000;
    send_word(x);
    x = {12{32'hFFFFFFFF}};
    x.d_s12_im = 32'h00000003;
    send_word(x);
    x = '0;
    x.s_r_im = 32'h80000000; x.d_s12_im = 32'h7FFFFFFF;
    x.s_k_im = 32'h40000000; x.d_k_re = 32'h80000000;
    send_word(x);
    // det 2 and small numerators; with the 2^16 scale the quotients come out exact
    x = '0;
    x.s_r_re = 32'd2; x.d_s12_re = 32'd1; x.s_k_re = 32'd3; x.d_k_re = -32'sd5;
    send_word(x);
    for (int i = 0; i < 8; i++) begin
      x = rnd_word();
      x.d_r_re = x.s_r_re; x.d_r_im = x.s_r_im;
      x.d_s12_re = x.s_s12_re; x.d_s12_im = x.s_s12_im;
      send_word(x);                     // equal rows, singular
    end
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_word(rnd_word());
  endtask

  task automatic test_back_to_back;
    start <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);  // hold off until all results are back
    burst_left = 200;
    test_random(150);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    burst_left = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_random(250);
    test_back_to_back();
    test_random(300);
    drain();
    if (n_err == 0 && want_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/c2cs_pkg.sv
hdl/c2cs_front.sv
hdl/c2cs_cell.sv
hdl/c2cs_round.sv
hdl/complex_2x2_cramer_solve.sv
tb/complex_2x2_cramer_solve_test.sv
